@@ rtl/hsfc_pkg.sv @@
`default_nettype none
package hsfc_pkg;

    localparam logic FUNC_H2S = 1'b0;
    localparam logic FUNC_S2H = 1'b1;

    localparam logic [7:0] SUBNORM_BASE_EXP = 8'd113;
    localparam logic [7:0] NORMAL_REBIAS    = 8'd112;
    localparam logic [7:0] SINGLE_EXP_MAX   = 8'hff;
    localparam logic [4:0] HALF_EXP_MAX     = 5'h1f;
    localparam logic [7:0] S2H_EXP_CEIL     = 8'd143;

    typedef struct packed {
        logic       func;
        logic       sign;
        logic [7:0] exp;
        logic [9:0] frac;
        logic [3:0] pos;
        logic       zero;
    } t_dec;

    typedef struct packed {
        logic       func;
        logic       sign;
        logic [7:0] exp;
        logic [9:0] frac;
    } t_res;

endpackage
`default_nettype wire

@@ rtl/half_single_float_converter.sv @@
// Half/single float format converter.
// Input channel: i_valid, i_func, i_operand; the block drives o_stall.
// i_func low converts the half in i_operand[15:0] to single (exact);
// i_func high converts the single in i_operand to half by truncating the
// mantissa to 10 bits and clamping the rebiased exponent to 0..31.
// Output channel: o_valid, o_converted; the receiver drives i_stall.
// Half results sit in o_converted[15:0] with the upper bits zero.
// Three register stages: decode with a leading one encoder, exponent
// rebias and fraction shift, then result assembly. An accepted input
// passes r_s1, r_s2 and r_out in that order, and o_valid rises when it
// reaches r_out.
// Throughput is one item per cycle while i_stall is low; every stage holds
// a valid bit and advances whenever the stage after it is empty or moving.
// While i_stall is high the output register holds its word, the stages
// behind it fill up, and o_stall rises once the first stage cannot move.
// i_rst_n is synchronous and active low; it empties every stage.
`default_nettype none
module half_single_float_converter
    import hsfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_operand,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_converted
);

    logic        r_v1, r_v2, r_v3;
    t_dec        r_s1, n_s1;
    t_res        r_s2, n_s2;
    logic [31:0] r_out, n_out;
    logic        w_rdy1, w_rdy2, w_rdy3;
    logic [3:0]  w_shift;

    assign w_rdy3 = !r_v3 || !i_stall;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign o_stall     = !w_rdy1;
    assign o_valid     = r_v3;
    assign o_converted = r_out;

    // stage 1: field split and leading one position
    always_comb begin
        n_s1      = '0;
        n_s1.func = i_func;
        if (i_func == FUNC_H2S) begin
            n_s1.sign = i_operand[15];
            n_s1.exp  = {3'b000, i_operand[14:10]};
            n_s1.frac = i_operand[9:0];
            n_s1.zero = (i_operand[14:0] == 15'd0);
        end else begin
            n_s1.sign = i_operand[31];
            n_s1.exp  = i_operand[30:23];
            n_s1.frac = i_operand[22:13];
            n_s1.zero = (i_operand[30:0] == 31'd0);
        end
        for (int k = 0; k < 10; k++) begin
            if (i_operand[k]) begin
                n_s1.pos = 4'(k);
            end
        end
    end

    // stage 2: exponent rebias and clamping, subnormal normalization
    assign w_shift = 4'd10 - r_s1.pos;

    always_comb begin
        n_s2      = '0;
        n_s2.func = r_s1.func;
        n_s2.sign = r_s1.sign;
        n_s2.frac = r_s1.frac;
        if (r_s1.func == FUNC_H2S) begin
            if (r_s1.zero) begin
                n_s2.exp = 8'd0;
            end else if (r_s1.exp == 8'd0) begin
                n_s2.exp  = SUBNORM_BASE_EXP - {4'd0, w_shift};
                n_s2.frac = r_s1.frac << w_shift;
            end else if (r_s1.exp == {3'b000, HALF_EXP_MAX}) begin
                n_s2.exp = SINGLE_EXP_MAX;
            end else begin
                n_s2.exp = r_s1.exp + NORMAL_REBIAS;
            end
        end else begin
            if (r_s1.zero) begin
                n_s2.sign = 1'b0;
                n_s2.exp  = 8'd0;
                n_s2.frac = 10'd0;
            end else if (r_s1.exp == SINGLE_EXP_MAX || r_s1.exp > S2H_EXP_CEIL) begin
                n_s2.exp = {3'b000, HALF_EXP_MAX};
            end else if (r_s1.exp < NORMAL_REBIAS) begin
                n_s2.exp = 8'd0;
            end else begin
                n_s2.exp = r_s1.exp - NORMAL_REBIAS;
            end
        end
    end

    // stage 3: pack result word
    always_comb begin
        if (r_s2.func == FUNC_H2S) begin
            n_out = {r_s2.sign, r_s2.exp, r_s2.frac, 13'd0};
        end else begin
            n_out = {16'd0, r_s2.sign, r_s2.exp[4:0], r_s2.frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (w_rdy3 && r_v2) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

@@ rtl/hsfc_checker.sv @@
`default_nettype none
module hsfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_converted
);

    // output word held while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_converted))
        else $error("output changed under stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // input backpressure only when the output side is blocked
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    // a transfer reaches the output when there is no backpressure
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall ##1 !i_stall ##1 !i_stall) |=> o_valid)
        else $error("transfer did not reach output in three cycles");

endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_converted (o_converted)
);
`default_nettype wire
